// ===== rtl/wprr_pkg.sv =====
package wprr_pkg;

  localparam int NUM_WORKERS_DEF = 32;

  localparam logic [15:0] ERR_LIMIT_RST    = 16'd5;
  localparam logic [15:0] BUSY_TIMEOUT_RST = 16'd90;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    MODE_SELECT = 2'd0,
    MODE_SET    = 2'd1,
    MODE_ERROR  = 2'd2,
    MODE_AUDIT  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NO_ACTIVE = 2'd1,
    STS_NONE_RDY  = 2'd2,
    STS_NO_WORKER = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    WS_NOT_READY = 3'd0,
    WS_STARTING  = 3'd1,
    WS_READY     = 3'd2,
    WS_WORKING   = 3'd3,
    WS_BUSY      = 3'd4
  } wstate_e;

  typedef enum logic {
    CFG_ERROR_LIMIT  = 1'b0,
    CFG_BUSY_TIMEOUT = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_AUD_FETCH,
    S_AUD_STEP,
    S_AUD_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic commit;
    logic aud_step;
    logic aud_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_audit;
    logic out_free;
    logic aud_last;
  } dp_sts_t;

endpackage

// ===== rtl/wprr_ctrl.sv =====
module wprr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  wprr_pkg::dp_sts_t    sts_i,
  output wprr_pkg::ctrl_cmd_t  cmd_o
);

  wprr_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wprr_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wprr_pkg::S_IDLE: begin
        if (req_valid_i) begin
          state_d = wprr_pkg::S_EXEC;
        end
      end
      wprr_pkg::S_EXEC: begin
        if (sts_i.is_audit) begin
          state_d = wprr_pkg::S_AUD_FETCH;
        end else if (sts_i.out_free) begin
          state_d = wprr_pkg::S_IDLE;
        end
      end
      wprr_pkg::S_AUD_FETCH: begin
        state_d = wprr_pkg::S_AUD_STEP;
      end
      wprr_pkg::S_AUD_STEP: begin
        if (sts_i.aud_last) begin
          state_d = wprr_pkg::S_AUD_DONE;
        end
      end
      wprr_pkg::S_AUD_DONE: begin
        if (sts_i.out_free) begin
          state_d = wprr_pkg::S_IDLE;
        end
      end
      default: state_d = wprr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o    = 1'b0;
    cmd_o          = '0;
    unique case (state_q)
      wprr_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.load  = req_valid_i;
      end
      wprr_pkg::S_EXEC: begin
        cmd_o.commit = !sts_i.is_audit && sts_i.out_free;
      end
      wprr_pkg::S_AUD_FETCH: ;
      wprr_pkg::S_AUD_STEP: begin
        cmd_o.aud_step = 1'b1;
      end
      wprr_pkg::S_AUD_DONE: begin
        cmd_o.aud_done = sts_i.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/wprr_dpath.sv =====
module wprr_dpath #(
  parameter int NUM_WORKERS = wprr_pkg::NUM_WORKERS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wprr_pkg::ctrl_cmd_t  cmd_i,
  output wprr_pkg::dp_sts_t    sts_o,
  input  logic [1:0]           mode_i,
  input  logic [5:0]           worker_index_i,
  input  logic [2:0]           new_state_i,
  input  logic [31:0]          now_seconds_i,
  input  logic [31:0]          present_mask_i,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           status_o,
  output logic [4:0]           chosen_index_o,
  output logic [5:0]           active_workers_o
);

  localparam int IW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;

  wprr_pkg::mode_e mode_q;
  logic [5:0]      idx_q;
  logic [2:0]      ns_q;
  logic [31:0]     now_q;
  logic [31:0]     mask_q;

  logic [15:0] limit_q;
  logic [15:0] tmo_q;

  logic [2:0]  wstate_q [NUM_WORKERS];
  logic [2:0]  wstate_d [NUM_WORKERS];
  logic [15:0] err_q    [NUM_WORKERS];
  logic [15:0] err_d    [NUM_WORKERS];
  logic [31:0] stamp_mem [NUM_WORKERS];
  logic [31:0] rdata_q;

  logic [5:0]    active_q, active_d;
  logic [IW-1:0] ptr_q, ptr_d;
  logic [IW-1:0] cnt_q;
  logic [IW-1:0] rd_addr;

  logic                 out_valid_q;
  logic [1:0]           out_status_q;
  logic [4:0]           out_chosen_q;
  logic [5:0]           out_active_q;

  wprr_pkg::status_e res_status;
  logic [IW-1:0]     res_chosen;

  logic [IW-1:0]     idx_w;
  logic              in_range;
  logic [15:0]       err_inc;
  logic [31:0]       elapsed;
  logic [2:0]        aud_old, aud_mid, aud_new;
  logic              aud_last;
  logic [NUM_WORKERS-1:0] rdy_vec, hi_vec;
  logic              hi_any, rdy_any;
  logic [IW-1:0]     hi_pick, rdy_pick;
  logic              out_free;
  logic              out_load;

  function automatic logic [5:0] act_upd(logic [5:0] a, logic [2:0] o, logic [2:0] n);
    logic [5:0] r;
    r = a;
    if (o == wprr_pkg::WS_NOT_READY && n != wprr_pkg::WS_NOT_READY) begin
      r = a + 6'd1;
    end else if (o != wprr_pkg::WS_NOT_READY && n == wprr_pkg::WS_NOT_READY &&
                 a != 6'd0) begin
      r = a - 6'd1;
    end
    return r;
  endfunction

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= wprr_pkg::mode_e'(mode_i);
      idx_q  <= worker_index_i;
      ns_q   <= new_state_i;
      now_q  <= now_seconds_i;
      mask_q <= present_mask_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= wprr_pkg::ERR_LIMIT_RST;
      tmo_q   <= wprr_pkg::BUSY_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (wprr_pkg::cfg_reg_e'(cfg_idx_i))
        wprr_pkg::CFG_ERROR_LIMIT:  limit_q <= cfg_data_i;
        wprr_pkg::CFG_BUSY_TIMEOUT: tmo_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign idx_w    = idx_q[IW-1:0];
  assign in_range = idx_q < 6'(NUM_WORKERS);
  assign err_inc  = (err_q[idx_w] == 16'hFFFF) ? err_q[idx_w] : err_q[idx_w] + 16'd1;
  assign aud_last = cnt_q == IW'(NUM_WORKERS - 1);
  assign rd_addr  = (cmd_i.aud_step && !aud_last) ? cnt_q + IW'(1) : cnt_q;

  // start stamp store
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && mode_q == wprr_pkg::MODE_SET && in_range &&
        ns_q == wprr_pkg::WS_WORKING) begin
      stamp_mem[idx_w] <= now_q;
    end
    rdata_q <= stamp_mem[rd_addr];
  end

  // audit of one worker per cycle
  assign elapsed = now_q - rdata_q;
  assign aud_old = wstate_q[cnt_q];
  assign aud_mid = (aud_old == wprr_pkg::WS_WORKING && elapsed > {16'd0, tmo_q}) ?
                   wprr_pkg::WS_BUSY : aud_old;
  assign aud_new = (aud_mid == wprr_pkg::WS_BUSY && !mask_q[cnt_q]) ?
                   wprr_pkg::WS_NOT_READY : aud_mid;

  // round robin search: first ready above the pointer, else lowest ready
  always_comb begin
    hi_any   = 1'b0;
    rdy_any  = 1'b0;
    hi_pick  = '0;
    rdy_pick = '0;
    for (int i = 0; i < NUM_WORKERS; i++) begin
      rdy_vec[i] = wstate_q[i] == wprr_pkg::WS_READY;
      hi_vec[i]  = rdy_vec[i] && (IW'(i) > ptr_q);
    end
    for (int i = NUM_WORKERS - 1; i >= 0; i--) begin
      if (hi_vec[i]) begin
        hi_any  = 1'b1;
        hi_pick = IW'(i);
      end
      if (rdy_vec[i]) begin
        rdy_any  = 1'b1;
        rdy_pick = IW'(i);
      end
    end
  end

  always_comb begin
    wstate_d   = wstate_q;
    err_d      = err_q;
    active_d   = active_q;
    ptr_d      = ptr_q;
    res_status = wprr_pkg::STS_OK;
    res_chosen = '0;
    if (cmd_i.commit) begin
      unique case (mode_q)
        wprr_pkg::MODE_SELECT: begin
          if (active_q == 6'd0) begin
            res_status = wprr_pkg::STS_NO_ACTIVE;
          end else if (rdy_any) begin
            ptr_d      = hi_any ? hi_pick : rdy_pick;
            res_chosen = hi_any ? hi_pick : rdy_pick;
          end else begin
            res_status = wprr_pkg::STS_NONE_RDY;
          end
        end
        wprr_pkg::MODE_SET: begin
          if (!in_range) begin
            res_status = wprr_pkg::STS_NO_WORKER;
          end else if (ns_q <= wprr_pkg::WS_BUSY) begin
            wstate_d[idx_w] = ns_q;
            active_d        = act_upd(active_q, wstate_q[idx_w], ns_q);
          end
        end
        wprr_pkg::MODE_ERROR: begin
          if (!in_range) begin
            res_status = wprr_pkg::STS_NO_WORKER;
          end else begin
            err_d[idx_w] = err_inc;
            if (err_inc >= limit_q) begin
              wstate_d[idx_w] = wprr_pkg::WS_BUSY;
              active_d        = act_upd(active_q, wstate_q[idx_w], wprr_pkg::WS_BUSY);
            end
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.aud_step) begin
      wstate_d[cnt_q] = aud_new;
      active_d        = act_upd(active_q, aud_old, aud_new);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WORKERS; i++) begin
        wstate_q[i] <= wprr_pkg::WS_NOT_READY;
        err_q[i]    <= '0;
      end
      active_q <= '0;
      ptr_q    <= '0;
      cnt_q    <= '0;
    end else begin
      wstate_q <= wstate_d;
      err_q    <= err_d;
      active_q <= active_d;
      ptr_q    <= ptr_d;
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.aud_step && !aud_last) begin
        cnt_q <= cnt_q + IW'(1);
      end
    end
  end

  // result register
  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = cmd_i.commit || cmd_i.aud_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= res_status;
      out_chosen_q <= 5'(res_chosen);
      out_active_q <= active_d;
    end
  end

  assign sts_o.is_audit = mode_q == wprr_pkg::MODE_AUDIT;
  assign sts_o.out_free = out_free;
  assign sts_o.aud_last = aud_last;

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign chosen_index_o   = out_chosen_q;
  assign active_workers_o = out_active_q;

endmodule

// ===== rtl/worker_pool_round_robin_dispatch.sv =====
// channel   | dir | signals                              | contents
// ----------+-----+--------------------------------------+---------------------------------
// s_axis    | in  | tvalid tready tdata[79:0] tuser[1:0] | request: mode in tuser, fields in tdata
// m_axis    | out | tvalid tready tdata[15:0]            | result: status, chosen, active count
// cfg       | in  | cfg_we_i cfg_idx_i cfg_data_i[15:0]  | 0 error limit, 1 busy timeout
//
// select, set state and error report first capture the request, then update the tables
// audit: one stamp memory read and one worker checked per cycle
// one request at a time; the result register frees the input side while a result waits
// a full result register holds back the update step until m_axis_tready
// rst_ni clears all worker states, error counts, active count and pointer at once
module worker_pool_round_robin_dispatch #(
  parameter int NUM_WORKERS = wprr_pkg::NUM_WORKERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // worker_index[5:0], new_state[8:6], now_seconds[40:9], present_mask[72:41], zero fill
  input  logic [79:0] s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[1:0], chosen_index[6:2], active_workers[12:7], zero fill
  output logic [15:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  wprr_pkg::ctrl_cmd_t cmd;
  wprr_pkg::dp_sts_t   sts;

  logic [1:0] status;
  logic [4:0] chosen_index;
  logic [5:0] active_workers;

  wprr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  wprr_dpath #(
    .NUM_WORKERS (NUM_WORKERS)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .mode_i           (s_axis_tuser),
    .worker_index_i   (s_axis_tdata[5:0]),
    .new_state_i      (s_axis_tdata[8:6]),
    .now_seconds_i    (s_axis_tdata[40:9]),
    .present_mask_i   (s_axis_tdata[72:41]),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .status_o         (status),
    .chosen_index_o   (chosen_index),
    .active_workers_o (active_workers)
  );

  assign m_axis_tdata = {3'b000, active_workers, chosen_index, status};

endmodule

// ===== rtl/wprr_checker.sv =====
module wprr_checker #(
  parameter int NUM_WORKERS = wprr_pkg::NUM_WORKERS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [79:0] s_axis_tdata,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        cfg_we_i,
  input logic        cfg_idx_i,
  input logic [15:0] cfg_data_i
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while busy");

  a_active_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[12:7] <= 6'(NUM_WORKERS))
    else $error("active count above pool size");

  a_chosen_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[6:2] != 5'd0 |->
      m_axis_tdata[1:0] == wprr_pkg::STS_OK && m_axis_tdata[6:2] < 6'(NUM_WORKERS))
    else $error("bad chosen worker");

  a_no_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == wprr_pkg::STS_NO_ACTIVE |->
      m_axis_tdata[12:7] == 6'd0)
    else $error("no active status with active workers");

endmodule

bind worker_pool_round_robin_dispatch wprr_checker #(
  .NUM_WORKERS (NUM_WORKERS)
) u_wprr_checker (.*);
